### rtl/sms_list_reply_parser_macros.svh
// Assertion macros used by the parser top level.
`ifndef SMS_LIST_REPLY_PARSER_MACROS_SVH
`define SMS_LIST_REPLY_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLRP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slrp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slrp: next-cycle check failed");

`endif

### rtl/slrp_pkg.sv
// Types, character codes and decode functions of the message-list reply parser.
package slrp_pkg;

    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_QUOTE = 8'h22;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_C     = 8'h43;
    localparam logic [7:0] CHR_M     = 8'h4D;
    localparam logic [7:0] CHR_G     = 8'h47;
    localparam logic [7:0] CHR_L     = 8'h4C;
    localparam logic [7:0] CHR_0     = 8'h30;
    localparam logic [7:0] CHR_9     = 8'h39;
    localparam logic [7:0] CHR_R     = 8'h52;
    localparam logic [7:0] CHR_U     = 8'h55;
    localparam logic [7:0] CHR_S     = 8'h53;
    localparam logic [7:0] CHR_A     = 8'h41;

    localparam logic [2:0] HDR_LEN      = 3'd5;
    localparam logic [2:0] STAT_POS_MAX = 3'd7;
    localparam logic [2:0] STAT_POS_5TH = 3'd4;

    typedef enum logic [3:0] {
        PH_HUNT       = 4'd0,
        PH_SKIP       = 4'd1,
        PH_SLOT       = 4'd2,
        PH_STAT_OPEN  = 4'd3,
        PH_STATUS     = 4'd4,
        PH_NUM_OPEN   = 4'd5,
        PH_NUMBER     = 4'd6,
        PH_ALPHA_OPEN = 4'd7,
        PH_ALPHA      = 4'd8,
        PH_DATE_OPEN  = 4'd9,
        PH_DATE       = 4'd10,
        PH_WAIT_NL    = 4'd11,
        PH_MESSAGE    = 4'd12
    } t_phase;

    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_NUMBER = 3'd1,
        KIND_DATE   = 3'd2,
        KIND_MSG    = 3'd3,
        KIND_END    = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_UNDEF      = 3'd0,
        ST_REC_UNREAD = 3'd1,
        ST_REC_READ   = 3'd2,
        ST_STO_UNSENT = 3'd3,
        ST_STO_SENT   = 3'd4,
        ST_ALL        = 3'd5
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  text_char;
        logic [15:0] slot_number;
        t_status     msg_status;
    } t_result;

    // Controls from the phase machine to the slot accumulator.
    typedef struct packed {
        logic       clear;
        logic       step;
        logic [3:0] digit;
    } t_acc_ctl;

    // Expected character of the "+CMGL" header at a match position.
    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = CHR_PLUS;
            3'd1:    c = CHR_C;
            3'd2:    c = CHR_M;
            3'd3:    c = CHR_G;
            3'd4:    c = CHR_L;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Status word from its first and fifth characters.
    function automatic t_status classify(input logic [7:0] first, input logic [7:0] fifth);
        t_status s;
        s = ST_UNDEF;
        if (first == CHR_R) begin
            if (fifth == CHR_U) s = ST_REC_UNREAD;
            else if (fifth == CHR_R) s = ST_REC_READ;
        end else if (first == CHR_S) begin
            if (fifth == CHR_U) s = ST_STO_UNSENT;
            else if (fifth == CHR_S) s = ST_STO_SENT;
        end else if (first == CHR_A) begin
            s = ST_ALL;
        end
        return s;
    endfunction

endpackage

### rtl/slrp_if.sv
// Valid/ready channel interfaces for reply bytes and parsed result beats.
interface slrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       new_reply;

    modport source (output valid, output rx_byte, output new_reply, input ready);
    modport sink   (input valid, input rx_byte, input new_reply, output ready);
endinterface

interface slrp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  text_char;
    logic [15:0] slot_number;
    logic [2:0]  msg_status;

    modport source (output valid, output kind, output text_char, output slot_number,
                    output msg_status, input ready);
    modport sink   (input valid, input kind, input text_char, input slot_number,
                    input msg_status, output ready);
endinterface

### rtl/sms_list_reply_parser.sv
// Top level of the message-list reply parser: input stage, parser and result stage.
//
// Usage:
//   i_in  carries one raw reply byte per beat (rx_byte) and new_reply, which
//         restarts the parser at the header hunt before that byte is parsed.
//   o_out carries zero or one result beat per input byte: a header with slot
//         and status, number, date/time and message characters, and a record
//         end after the message line's newline. Carriage returns are dropped.
//   Path: a byte is held in the input register and its result in the result
//   register, which drives o_out; a result is valid on o_out once it is loaded
//   there.
//   Throughput: one byte per cycle while o_out is not held off; the parser's
//   phase state and slot accumulator update once per byte.
//   Stall: while o_out is held off, the result register keeps its beat and
//   the input register takes one more byte if empty; after that i_in.ready drops
//   until the result register frees up. No beat is lost or repeated.
//   Reset (synchronous, active low): both registers empty, parser hunting for
//   the "+CMGL" header with all counters and captured status cleared.
//   SLOT_BITS sets the accumulator width; it saturates at all ones and the
//   low 16 bits travel in slot_number.
module sms_list_reply_parser
    import slrp_pkg::*;
#(
    parameter int SLOT_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    slrp_in_if.sink           i_in,
    slrp_out_if.source        o_out
);

`include "sms_list_reply_parser_macros.svh"

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_new;

    // result register
    logic       r_out_valid;
    t_result    r_out;

    logic                  w_adv;
    logic                  w_step;
    logic                  w_emit;
    t_result               w_result;
    t_acc_ctl              w_acc_ctl;
    logic [SLOT_BITS-1:0]  w_acc;
    logic [SLOT_BITS+15:0] w_acc_ext;

    // result stage can take a new beat when empty or draining this cycle
    assign w_adv      = !r_out_valid || o_out.ready;
    assign w_step     = r_in_valid && w_adv;
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.rx_byte;
            r_in_new  <= i_in.new_reply;
        end
    end

    // zero-extend or truncate the accumulator to the 16-bit slot field
    assign w_acc_ext = {16'h0000, w_acc};

    slrp_slot_acc #(
        .SLOT_BITS (SLOT_BITS)
    ) u_slot_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_step),
        .i_ctl   (w_acc_ctl),
        .o_acc   (w_acc)
    );

    slrp_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_step),
        .i_byte      (r_in_byte),
        .i_new_reply (r_in_new),
        .i_slot      (w_acc_ext[15:0]),
        .o_acc_ctl   (w_acc_ctl),
        .o_emit      (w_emit),
        .o_result    (w_result)
    );

    // load a result beat, or drop the slot when the byte produced nothing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out.kind;
    assign o_out.text_char   = r_out.text_char;
    assign o_out.slot_number = r_out.slot_number;
    assign o_out.msg_status  = r_out.msg_status;

    `SLRP_ASSERT_IMP(a_cr_no_result, i_clk, i_rst_n, w_step && r_in_byte == CHR_CR, !w_emit)
    `SLRP_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid && $stable(r_in_byte))
    `SLRP_ASSERT_IMP(a_hdr_only_fields, i_clk, i_rst_n, o_out.valid && o_out.kind != KIND_HEADER, o_out.slot_number == 16'h0000 && o_out.msg_status == ST_UNDEF)
    `SLRP_ASSERT_IMP(a_char_only_text, i_clk, i_rst_n, o_out.valid && (o_out.kind == KIND_HEADER || o_out.kind == KIND_END), o_out.text_char == 8'h00)

endmodule

### rtl/slrp_slot_acc.sv
// Saturating decimal accumulator for the message slot number.
module slrp_slot_acc
    import slrp_pkg::*;
#(
    parameter int SLOT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_acc_ctl             i_ctl,
    output logic [SLOT_BITS-1:0] o_acc
);

    localparam int PROD_BITS = SLOT_BITS + 4;

    logic [SLOT_BITS-1:0] r_acc;
    logic [SLOT_BITS-1:0] n_acc;
    logic [PROD_BITS-1:0] w_sum;

    // acc * 10 + digit as two shifts and adds
    assign w_sum = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                 + {{(PROD_BITS-4){1'b0}}, i_ctl.digit};

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (i_ctl.step) begin
            if (w_sum[PROD_BITS-1:SLOT_BITS] != 4'b0) n_acc = '1;
            else n_acc = w_sum[SLOT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

### rtl/slrp_fsm.sv
// Phase machine: header hunt, field walk, status capture and result decode.
module slrp_fsm
    import slrp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    input  logic        i_new_reply,
    input  logic [15:0] i_slot,
    output t_acc_ctl    o_acc_ctl,
    output logic        o_emit,
    output t_result     o_result
);

    t_phase     r_phase, n_phase, c_phase;
    logic [2:0] r_match, n_match, c_match;
    logic [1:0] r_skip,  n_skip,  c_skip;
    logic [7:0] r_first, n_first;
    logic [7:0] r_fifth, n_fifth;
    logic [2:0] r_pos,   n_pos;
    logic [2:0] w_match_inc;
    logic [1:0] w_skip_inc;
    logic       w_digit;

    assign w_digit     = (i_byte >= CHR_0) && (i_byte <= CHR_9);
    assign w_skip_inc  = c_skip + 2'd1;

    always_comb begin
        // new reply restarts the hunt before this byte
        c_phase = i_new_reply ? PH_HUNT : r_phase;
        c_match = i_new_reply ? 3'd0 : r_match;
        c_skip  = i_new_reply ? 2'd0 : r_skip;

        n_phase = c_phase;
        n_match = c_match;
        n_skip  = c_skip;
        n_first = i_new_reply ? 8'h00 : r_first;
        n_fifth = i_new_reply ? 8'h00 : r_fifth;
        n_pos   = i_new_reply ? 3'd0 : r_pos;

        w_match_inc = 3'd0;
        o_acc_ctl.clear = i_new_reply;
        o_acc_ctl.step  = 1'b0;
        o_acc_ctl.digit = 4'(i_byte - CHR_0);
        o_emit = 1'b0;
        o_result.kind        = KIND_HEADER;
        o_result.text_char   = 8'h00;
        o_result.slot_number = 16'h0000;
        o_result.msg_status  = ST_UNDEF;

        if (i_byte != CHR_CR) begin
            unique case (c_phase)
                PH_HUNT: begin
                    if (c_match < HDR_LEN && i_byte == hdr_char(c_match))
                        w_match_inc = c_match + 3'd1;
                    else
                        w_match_inc = (i_byte == CHR_PLUS) ? 3'd1 : 3'd0;
                    n_match = w_match_inc;
                    if (w_match_inc == HDR_LEN) begin
                        n_match = 3'd0;
                        n_skip  = 2'd0;
                        o_acc_ctl.clear = 1'b1;
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_skip = w_skip_inc;
                    if (w_skip_inc >= 2'd2) begin
                        n_skip  = 2'd0;
                        n_phase = PH_SLOT;
                    end
                end
                PH_SLOT: begin
                    if (w_digit) o_acc_ctl.step = 1'b1;
                    else n_phase = PH_STAT_OPEN;
                end
                PH_STAT_OPEN: begin
                    if (i_byte == CHR_QUOTE) begin
                        n_first = 8'h00;
                        n_fifth = 8'h00;
                        n_pos   = 3'd0;
                        n_phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (i_byte == CHR_QUOTE) begin
                        n_phase = PH_NUM_OPEN;
                        o_emit  = 1'b1;
                        o_result.kind        = KIND_HEADER;
                        o_result.slot_number = i_slot;
                        o_result.msg_status  = classify(r_first, r_fifth);
                    end else begin
                        if (r_pos == 3'd0) n_first = i_byte;
                        if (r_pos == STAT_POS_5TH) n_fifth = i_byte;
                        if (r_pos < STAT_POS_MAX) n_pos = r_pos + 3'd1;
                    end
                end
                PH_NUM_OPEN: begin
                    if (i_byte == CHR_QUOTE) n_phase = PH_NUMBER;
                end
                PH_NUMBER: begin
                    if (i_byte == CHR_QUOTE) begin
                        n_phase = PH_ALPHA_OPEN;
                    end else begin
                        o_emit = 1'b1;
                        o_result.kind      = KIND_NUMBER;
                        o_result.text_char = i_byte;
                    end
                end
                PH_ALPHA_OPEN: begin
                    if (i_byte == CHR_QUOTE) n_phase = PH_ALPHA;
                end
                PH_ALPHA: begin
                    if (i_byte == CHR_QUOTE) n_phase = PH_DATE_OPEN;
                end
                PH_DATE_OPEN: begin
                    if (i_byte == CHR_QUOTE) n_phase = PH_DATE;
                end
                PH_DATE: begin
                    if (i_byte == CHR_QUOTE) begin
                        n_phase = PH_WAIT_NL;
                    end else begin
                        o_emit = 1'b1;
                        o_result.kind      = KIND_DATE;
                        o_result.text_char = i_byte;
                    end
                end
                PH_WAIT_NL: begin
                    if (i_byte == CHR_LF) n_phase = PH_MESSAGE;
                end
                PH_MESSAGE: begin
                    o_emit = 1'b1;
                    if (i_byte == CHR_LF) begin
                        n_phase = PH_HUNT;
                        n_match = 3'd0;
                        o_result.kind = KIND_END;
                    end else begin
                        o_result.kind      = KIND_MSG;
                        o_result.text_char = i_byte;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    n_match = 3'd0;
                    n_skip  = 2'd0;
                    n_first = 8'h00;
                    n_fifth = 8'h00;
                    n_pos   = 3'd0;
                    o_acc_ctl.clear = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_match <= 3'd0;
            r_skip  <= 2'd0;
            r_first <= 8'h00;
            r_fifth <= 8'h00;
            r_pos   <= 3'd0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_match <= n_match;
            r_skip  <= n_skip;
            r_first <= n_first;
            r_fifth <= n_fifth;
            r_pos   <= n_pos;
        end
    end

endmodule

### test/sms_list_reply_parser_checker.sv
// Result checker for the message-list reply parser: byte-level predictor and beat scoreboard.
`timescale 1ns / 100ps

module sms_list_reply_parser_checker
    import slrp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    slrp_in_if   i_in,
    slrp_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);

    localparam string HEADER_TEXT = "+CMGL";

    // Predictor copy of the parser state.
    t_phase      parse_phase;
    logic [2:0]  hdr_matched;
    logic [1:0]  skip_seen;
    logic [15:0] slot_value;
    logic [7:0]  word_first;
    logic [7:0]  word_fifth;
    logic [2:0]  word_pos;

    t_result     expected_beats [$];
    t_result     predicted;
    t_result     oldest;
    int          fail_count    = 0;
    int          pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic void clear_parse_state();
        parse_phase = PH_HUNT;
        hdr_matched = '0;
        skip_seen   = '0;
        slot_value  = '0;
        word_first  = '0;
        word_fifth  = '0;
        word_pos    = '0;
    endfunction

    // Status from the first and fifth characters of the quoted word.
    function automatic t_status status_from_word(input logic [7:0] first,
                                                 input logic [7:0] fifth);
        t_status st;
        st = ST_UNDEF;
        case (first)
            CHR_R:   st = (fifth == CHR_U) ? ST_REC_UNREAD :
                          (fifth == CHR_R) ? ST_REC_READ : ST_UNDEF;
            CHR_S:   st = (fifth == CHR_U) ? ST_STO_UNSENT :
                          (fifth == CHR_S) ? ST_STO_SENT : ST_UNDEF;
            CHR_A:   st = ST_ALL;
            default: st = ST_UNDEF;
        endcase
        return st;
    endfunction

    // Advance the predictor by one byte; return 1 when the byte yields a result beat.
    function automatic bit parse_byte(input logic [7:0] b, input logic restart,
                                      output t_result beat);
        logic [31:0] grown;
        bit          emits;
        beat  = '{kind: KIND_HEADER, text_char: 8'h00, slot_number: 16'h0000,
                  msg_status: ST_UNDEF};
        emits = 1'b0;
        if (restart) clear_parse_state();
        if (b == CHR_CR) return 1'b0;
        case (parse_phase)
            PH_HUNT: begin
                if (hdr_matched < HDR_LEN && b == HEADER_TEXT[hdr_matched])
                    hdr_matched = hdr_matched + 3'd1;
                else
                    hdr_matched = (b == CHR_PLUS) ? 3'd1 : 3'd0;
                if (hdr_matched == HDR_LEN) begin
                    hdr_matched = '0;
                    skip_seen   = '0;
                    slot_value  = '0;
                    parse_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                skip_seen = skip_seen + 2'd1;
                if (skip_seen >= 2'd2) begin
                    skip_seen   = '0;
                    parse_phase = PH_SLOT;
                end
            end
            PH_SLOT: begin
                if (b >= CHR_0 && b <= CHR_9) begin
                    grown = 32'(slot_value) * 32'd10 + 32'(b - CHR_0);
                    if (grown > 32'h0000_FFFF) grown = 32'h0000_FFFF;
                    slot_value = grown[15:0];
                end else begin
                    parse_phase = PH_STAT_OPEN;
                end
            end
            PH_STAT_OPEN: begin
                if (b == CHR_QUOTE) begin
                    word_first  = '0;
                    word_fifth  = '0;
                    word_pos    = '0;
                    parse_phase = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (b == CHR_QUOTE) begin
                    parse_phase      = PH_NUM_OPEN;
                    beat.slot_number = slot_value;
                    beat.msg_status  = status_from_word(word_first, word_fifth);
                    emits            = 1'b1;
                end else begin
                    if (word_pos == 3'd0) word_first = b;
                    if (word_pos == STAT_POS_5TH) word_fifth = b;
                    if (word_pos < STAT_POS_MAX) word_pos = word_pos + 3'd1;
                end
            end
            PH_NUM_OPEN:   if (b == CHR_QUOTE) parse_phase = PH_NUMBER;
            PH_NUMBER: begin
                if (b == CHR_QUOTE) begin
                    parse_phase = PH_ALPHA_OPEN;
                end else begin
                    beat.kind      = KIND_NUMBER;
                    beat.text_char = b;
                    emits          = 1'b1;
                end
            end
            PH_ALPHA_OPEN: if (b == CHR_QUOTE) parse_phase = PH_ALPHA;
            PH_ALPHA:      if (b == CHR_QUOTE) parse_phase = PH_DATE_OPEN;
            PH_DATE_OPEN:  if (b == CHR_QUOTE) parse_phase = PH_DATE;
            PH_DATE: begin
                if (b == CHR_QUOTE) begin
                    parse_phase = PH_WAIT_NL;
                end else begin
                    beat.kind      = KIND_DATE;
                    beat.text_char = b;
                    emits          = 1'b1;
                end
            end
            PH_WAIT_NL:    if (b == CHR_LF) parse_phase = PH_MESSAGE;
            PH_MESSAGE: begin
                if (b == CHR_LF) begin
                    parse_phase = PH_HUNT;
                    hdr_matched = '0;
                    beat.kind   = KIND_END;
                end else begin
                    beat.kind      = KIND_MSG;
                    beat.text_char = b;
                end
                emits = 1'b1;
            end
            default: clear_parse_state();
        endcase
        return emits;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse_state();
            expected_beats.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: result beat with nothing expected: kind=%0d char=%02h slot=%0d status=%0d",
                             $time, i_out.kind, i_out.text_char, i_out.slot_number,
                             i_out.msg_status);
                    fail_count++;
                end else begin
                    oldest = expected_beats.pop_front();
                    if (i_out.kind !== oldest.kind || i_out.text_char !== oldest.text_char ||
                        i_out.slot_number !== oldest.slot_number ||
                        i_out.msg_status !== oldest.msg_status) begin
                        $display("%0t: beat mismatch: expected kind=%0d char=%02h slot=%0d status=%0d, actual kind=%0d char=%02h slot=%0d status=%0d",
                                 $time, oldest.kind, oldest.text_char, oldest.slot_number,
                                 oldest.msg_status, i_out.kind, i_out.text_char,
                                 i_out.slot_number, i_out.msg_status);
                        fail_count++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (parse_byte(i_in.rx_byte, i_in.new_reply, predicted))
                    expected_beats.push_back(predicted);
            end
        end
        pending_count = expected_beats.size();
    end

endmodule

### test/sms_list_reply_parser_test.sv
// Testbench top for the message-list reply parser: clock, reset, reply stimulus and verdict.
`timescale 1ns / 100ps

module sms_list_reply_parser_test;
    import slrp_pkg::*;

    // Idle regimes: heavy receiver idling first, then heavy sender idling, then none.
    typedef enum int {
        IDLE_RX_HEAVY = 0,
        IDLE_TX_HEAVY = 1,
        IDLE_OFF      = 2
    } t_idle_mode;

    localparam int TX_IDLE_PCT [3] = '{17, 66, 0};
    localparam int RX_IDLE_PCT [3] = '{66, 17, 0};

    // Long receiver hold-off, so the two register stages fill and stall the input.
    localparam int HOLD_CYCLES    = 150;
    // Longest stretch with no beat on either side; well above the hold-off plus idle runs.
    localparam int STALL_LIMIT    = 2000;
    // Beats needed after the directed part, split evenly over the three regimes.
    localparam int RANDOM_BYTES   = 1900;
    // Two register stages; give the block a few extra cycles after the last beat.
    localparam int DRAIN_CYCLES   = 8;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;

    slrp_in_if  in_ch ();
    slrp_out_if out_ch ();

    t_idle_mode idle_mode    = IDLE_RX_HEAVY;
    logic       hold_req_tgl = 1'b0;
    logic       hold_seen    = 1'b0;
    int         hold_left    = 0;
    int         stall_cycles = 0;
    int         bytes_sent   = 0;
    int         fail_count;
    int         pending;

    // Reply bytes of the record being built, sent front to back.
    logic [7:0] rec_bytes [$];
    bit         restart_next = 1'b0;

    string status_words [8] = '{"REC UNREAD", "REC READ", "STO UNSENT", "STO SENT",
                                "ALL", "REC XXXX", "S", "STO"};

    sms_list_reply_parser u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sms_list_reply_parser_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 clk = ~clk;

    // Any byte but the one given.
    function automatic logic [7:0] rand_except(input logic [7:0] excluded);
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == excluded) b = 8'($urandom_range(255));
        return b;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) rec_bytes.push_back(s[i]);
    endtask

    // Append up to max_len random bytes that never close the field.
    task automatic add_field(input int max_len, input logic [7:0] terminator);
        repeat ($urandom_range(max_len)) rec_bytes.push_back(rand_except(terminator));
    endtask

    // Offer one byte and hold it until the block takes it. Ready is sampled at the
    // falling edge, where it is settled, so the beat is known to move at the next
    // rising edge.
    task automatic send_byte(input logic [7:0] b, input logic restart);
        bit taken;
        while ($urandom_range(99) < TX_IDLE_PCT[idle_mode]) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.rx_byte   <= b;
        in_ch.new_reply <= restart;
        do begin
            @(negedge clk);
            taken = in_ch.ready;
            @(posedge clk);
        end while (!taken);
        bytes_sent++;
    endtask

    // Send the built record, raising new_reply on its first byte when asked.
    task automatic send_record(input logic restart_first);
        foreach (rec_bytes[i]) send_byte(rec_bytes[i], restart_first && i == 0);
        rec_bytes.delete();
    endtask

    // One regime of random traffic: mostly well-formed records with random content,
    // the rest line noise and records cut short by a new reply.
    task automatic run_random(input t_idle_mode mode, input int budget);
        int         stop_at;
        int         pick;
        int         digits;
        logic       restart;
        idle_mode    <= mode;
        hold_req_tgl <= ~hold_req_tgl;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            pick    = $urandom_range(99);
            restart = restart_next || ($urandom_range(99) < 15);
            restart_next = 1'b0;
            if (pick < 10) begin
                // Noise biased toward the characters the parser reacts to.
                repeat ($urandom_range(1, 15)) begin
                    case ($urandom_range(9))
                        0:       rec_bytes.push_back(CHR_PLUS);
                        1:       rec_bytes.push_back(CHR_C);
                        2:       rec_bytes.push_back(CHR_L);
                        3:       rec_bytes.push_back(CHR_CR);
                        4:       rec_bytes.push_back(CHR_QUOTE);
                        5:       rec_bytes.push_back(CHR_LF);
                        default: rec_bytes.push_back(8'($urandom_range(255)));
                    endcase
                end
            end else begin
                add_field(2, CHR_PLUS);
                add_text(($urandom_range(7) == 0) ? "+CM\rGL" : "+CMGL");
                rec_bytes.push_back(8'($urandom_range(255)));
                rec_bytes.push_back(8'($urandom_range(255)));
                // Mostly short slots; now and then enough digits to saturate.
                digits = ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
                repeat (digits) rec_bytes.push_back(CHR_0 + 8'($urandom_range(9)));
                add_text(",\"");
                if ($urandom_range(9) < 7) add_text(status_words[$urandom_range(7)]);
                else add_field(9, CHR_QUOTE);
                add_text("\",\"");
                add_field(12, CHR_QUOTE);
                add_text("\",\"");
                add_field(6, CHR_QUOTE);
                add_text("\",\"");
                if ($urandom_range(1) == 0)
                    add_text($sformatf("%02d/%02d/%02d,%02d:%02d:%02d+%02d",
                                       $urandom_range(99), $urandom_range(12),
                                       $urandom_range(31), $urandom_range(23),
                                       $urandom_range(59), $urandom_range(59),
                                       $urandom_range(99)));
                else
                    add_field(20, CHR_QUOTE);
                add_text("\"\r\n");
                add_field(30, CHR_LF);
                add_text("\r\n");
                // Cut the record short; the next one opens a new reply.
                if (pick < 20) begin
                    rec_bytes    = rec_bytes[0:$urandom_range(rec_bytes.size() - 1)];
                    restart_next = 1'b1;
                end
            end
            send_record(restart);
        end
    endtask

    // Receiver: random idling per regime, plus one long hold-off per regime.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req_tgl != hold_seen) begin
                hold_seen = hold_req_tgl;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= RX_IDLE_PCT[idle_mode]);
            end
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("sms_list_reply_parser_test: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.rx_byte   = 8'h00;
        in_ch.new_reply = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes with new_reply, a partial header restarted by '+',
        // a carriage return inside the header, slot saturation, a one-letter status
        // word, an empty alpha field, message bytes at both extremes and a quote.
        rec_bytes.push_back(8'hFF);
        rec_bytes.push_back(8'h00);
        add_text("+C+CM\rGL: 99999,\"A\"\"7\"\"\"\"9\"\n");
        rec_bytes.push_back(8'hFF);
        rec_bytes.push_back(8'h00);
        add_text("\"\n");
        send_record(1'b1);
        // Empty slot, unknown status word, then a reply abandoned mid-number.
        add_text("+CMGL::,\"REC Q\"\"5");
        send_record(1'b0);
        restart_next = 1'b1;

        run_random(IDLE_RX_HEAVY, RANDOM_BYTES / 3);
        run_random(IDLE_TX_HEAVY, RANDOM_BYTES / 3);
        run_random(IDLE_OFF, RANDOM_BYTES - 2 * (RANDOM_BYTES / 3));
        in_ch.valid <= 1'b0;

        // Drain: the watchdog covers a block that stops producing beats.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("sms_list_reply_parser_test: PASS");
        end else begin
            $display("sms_list_reply_parser_test: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/slrp_pkg.sv
rtl/slrp_if.sv
rtl/slrp_slot_acc.sv
rtl/slrp_fsm.sv
rtl/sms_list_reply_parser.sv
test/sms_list_reply_parser_checker.sv
test/sms_list_reply_parser_test.sv
